@@ design/message_frame_deframer_assert.svh @@
// Assertion macros used by the deframer checker.
`ifndef MESSAGE_FRAME_DEFRAMER_ASSERT_SVH
`define MESSAGE_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MFD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define MFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer next-cycle check failed");

`endif

@@ design/mfd_pkg.sv @@
`timescale 1ns / 1ps

package mfd_pkg;

  // Section codes, also reported as the byte kind
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_TOPIC   = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_SIG     = 3'd3;
  localparam logic [2:0] PH_KEY     = 3'd4;

  localparam logic [31:0] HDR_BYTES = 32'd16;
  localparam logic [31:0] KEY_BYTES = 32'd4;

  // Config register indexes
  localparam logic [1:0] REG_VERSION   = 2'd0;
  localparam logic [1:0] REG_SIGNED_PUB = 2'd1;
  localparam logic [1:0] REG_SIGNED_MSG = 2'd2;

  // Output bus layout
  localparam int TDATA_W = 168;
  localparam int TUSER_W = 5;
  localparam int OFS_SIGNED  = 8;
  localparam int OFS_CMD     = 9;
  localparam int OFS_SEQ     = 17;
  localparam int OFS_TOPIC   = 81;
  localparam int OFS_PAYLOAD = 97;
  localparam int OFS_KEY     = 129;
  localparam int OFS_END     = 161;
  localparam int UOFS_HDR    = 3;
  localparam int UOFS_VERR   = 4;

  typedef struct packed {
    logic [7:0] expected_version;
    logic [7:0] signed_publish_code;
    logic [7:0] signed_message_code;
  } mfd_cfg_t;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [7:0]  byte_value;
    logic        header_done;
    logic        frame_done;
    logic        signed_frame;
    logic [7:0]  command_code;
    logic [63:0] sequence_number;
    logic [15:0] topic_length;
    logic [31:0] payload_length;
    logic [31:0] key_identifier;
    logic        version_error;
  } mfd_result_t;

endpackage

@@ design/mfd_in_stage.sv @@
`timescale 1ns / 1ps

// Input register: holds one byte until the core consumes it.
module mfd_in_stage import mfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_valid,
  output logic       s_ready,
  input  logic [7:0] s_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  // Free when empty or when the held byte moves on this cycle; closed in reset
  assign s_ready = !rst && (!held_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_ready) begin
      held_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      held_byte <= s_byte;
    end
  end

endmodule

@@ design/mfd_core.sv @@
`timescale 1ns / 1ps

// Frame parser: section tracking and header/key assembly, one byte a cycle while advance is high.
module mfd_core import mfd_pkg::*; #(
  parameter int SIG_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  mfd_cfg_t    cfg,
  input  logic        advance,
  input  logic [7:0]  in_byte,
  output mfd_result_t result
);

  localparam logic [31:0] SIG_LEN = 32'(SIG_BYTES);

  logic [2:0]  phase, phase_next;
  logic [31:0] byte_count, byte_count_next;
  logic [7:0]  cur_command, cur_command_next;
  logic [63:0] cur_sequence, cur_sequence_next;
  logic [15:0] cur_topic_len, cur_topic_len_next;
  logic [31:0] cur_payload_len, cur_payload_len_next;
  logic [31:0] cur_key_id, cur_key_id_next;
  logic        cur_signed, cur_signed_next;

  logic [2:0]  phase_eff;
  logic [2:0]  section_nxt;
  logic [31:0] sec_len;
  logic [32:0] count_inc;
  logic        sec_end;
  logic        verr;
  logic        hdr_done;
  logic        frm_done;

  assign count_inc = {1'b0, byte_count} + 33'd1;

  always_comb begin
    phase_eff            = (phase > PH_KEY) ? PH_HEADER : phase;
    cur_command_next     = cur_command;
    cur_sequence_next    = cur_sequence;
    cur_topic_len_next   = cur_topic_len;
    cur_payload_len_next = cur_payload_len;
    cur_key_id_next      = cur_key_id;
    cur_signed_next      = cur_signed;
    verr                 = 1'b0;
    hdr_done             = 1'b0;
    sec_len              = '0;

    unique case (phase_eff)
      PH_TOPIC:   sec_len = {16'd0, cur_topic_len};
      PH_PAYLOAD: sec_len = cur_payload_len;
      PH_SIG:     sec_len = SIG_LEN;
      PH_KEY: begin
        sec_len         = KEY_BYTES;
        cur_key_id_next = {cur_key_id[23:0], in_byte};
      end
      default: begin
        // Header: field chosen by byte position
        if (byte_count == 32'd0) begin
          cur_command_next     = '0;
          cur_sequence_next    = '0;
          cur_topic_len_next   = '0;
          cur_payload_len_next = '0;
          cur_key_id_next      = '0;
          cur_signed_next      = 1'b0;
          verr = (in_byte != cfg.expected_version);
        end else if (byte_count == 32'd1) begin
          cur_command_next = in_byte;
          cur_signed_next  = (in_byte == cfg.signed_publish_code) ||
                             (in_byte == cfg.signed_message_code);
        end else if (byte_count < 32'd10) begin
          cur_sequence_next = {cur_sequence[55:0], in_byte};
        end else if (byte_count < 32'd12) begin
          cur_topic_len_next = {cur_topic_len[7:0], in_byte};
        end else begin
          cur_payload_len_next = {cur_payload_len[23:0], in_byte};
        end
        sec_len  = HDR_BYTES;
        hdr_done = !verr && (count_inc >= {1'b0, HDR_BYTES});
      end
    endcase

    sec_end = (sec_len == 32'd0) || (count_inc >= {1'b0, sec_len});

    // First non-empty section after this one; header means frame over
    if (phase_eff < PH_TOPIC && cur_topic_len_next != 16'd0) begin
      section_nxt = PH_TOPIC;
    end else if (phase_eff < PH_PAYLOAD && cur_payload_len_next != 32'd0) begin
      section_nxt = PH_PAYLOAD;
    end else if (phase_eff < PH_SIG && cur_signed_next) begin
      section_nxt = PH_SIG;
    end else if (phase_eff == PH_SIG) begin
      section_nxt = PH_KEY;
    end else begin
      section_nxt = PH_HEADER;
    end

    frm_done = 1'b0;
    if (verr) begin
      phase_next      = PH_HEADER;
      byte_count_next = '0;
    end else if (sec_end) begin
      phase_next      = section_nxt;
      byte_count_next = '0;
      frm_done        = (section_nxt == PH_HEADER);
    end else begin
      phase_next      = phase_eff;
      byte_count_next = count_inc[31:0];
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      byte_count      <= '0;
      cur_command     <= '0;
      cur_sequence    <= '0;
      cur_topic_len   <= '0;
      cur_payload_len <= '0;
      cur_key_id      <= '0;
      cur_signed      <= 1'b0;
    end else if (advance) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      cur_command     <= cur_command_next;
      cur_sequence    <= cur_sequence_next;
      cur_topic_len   <= cur_topic_len_next;
      cur_payload_len <= cur_payload_len_next;
      cur_key_id      <= cur_key_id_next;
      cur_signed      <= cur_signed_next;
    end
  end

  // Result for the byte being consumed
  always_comb begin
    result.byte_kind       = phase_eff;
    result.byte_value      = in_byte;
    result.header_done     = hdr_done;
    result.frame_done      = frm_done;
    result.signed_frame    = cur_signed_next;
    result.command_code    = cur_command_next;
    result.sequence_number = cur_sequence_next;
    result.topic_length    = cur_topic_len_next;
    result.payload_length  = cur_payload_len_next;
    result.key_identifier  = cur_key_id_next;
    result.version_error   = verr;
  end

endmodule

@@ design/mfd_out_stage.sv @@
`timescale 1ns / 1ps

// Result register and stream packing.
module mfd_out_stage import mfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  mfd_result_t          result,
  output logic                 free,
  output logic                 m_valid,
  input  logic                 m_ready,
  output logic [TDATA_W-1:0]   m_data,
  output logic [TUSER_W-1:0]   m_user,
  output logic                 m_last
);

  mfd_result_t held;

  assign free = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (free) begin
      m_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  // Pack fields, lowest first
  always_comb begin
    m_data                              = '0;
    m_data[OFS_SIGNED-1:0]              = held.byte_value;
    m_data[OFS_SIGNED]                  = held.signed_frame;
    m_data[OFS_SEQ-1:OFS_CMD]           = held.command_code;
    m_data[OFS_TOPIC-1:OFS_SEQ]         = held.sequence_number;
    m_data[OFS_PAYLOAD-1:OFS_TOPIC]     = held.topic_length;
    m_data[OFS_KEY-1:OFS_PAYLOAD]       = held.payload_length;
    m_data[OFS_END-1:OFS_KEY]           = held.key_identifier;
    m_user[UOFS_HDR-1:0]                = held.byte_kind;
    m_user[UOFS_HDR]                    = held.header_done;
    m_user[UOFS_VERR]                   = held.version_error;
    m_last                              = held.frame_done;
  end

endmodule

@@ design/message_frame_deframer.sv @@
`timescale 1ns / 1ps
// Byte-serial frame deframer: one result per input byte.
// Path: an accepted byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle while the result stream is not stalled; the parser state updates in a single pass.
// Reset (rst, synchronous, active high): parser waits for a header start,
// frame fields clear, config returns to version 1 and both signed codes 0.
module message_frame_deframer import mfd_pkg::*; #(
  parameter int SIG_BYTES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] byte_value, [8] signed_frame, [16:9] command_code,
  // [80:17] sequence_number, [96:81] topic_length, [128:97] payload_length,
  // [160:129] key_identifier, [167:161] zero
  output logic [TDATA_W-1:0]  m_axis_tdata,
  // [2:0] byte_kind, [3] header_done, [4] version_error
  output logic [TUSER_W-1:0]  m_axis_tuser,
  output logic                m_axis_tlast,   // frame_done
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  mfd_cfg_t    cfg;
  mfd_result_t result;
  logic        held_valid;
  logic [7:0]  held_byte;
  logic        out_free;
  logic        advance;

  // Config registers
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_version    <= 8'd1;
      cfg.signed_publish_code <= 8'd0;
      cfg.signed_message_code <= 8'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_VERSION:    cfg.expected_version    <= cfg_data;
        REG_SIGNED_PUB: cfg.signed_publish_code <= cfg_data;
        REG_SIGNED_MSG: cfg.signed_message_code <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance = held_valid && out_free;

  mfd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_byte     (s_axis_tdata),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  mfd_core #(
    .SIG_BYTES (SIG_BYTES)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .in_byte (held_byte),
    .result  (result)
  );

  mfd_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (advance),
    .result  (result),
    .free    (out_free),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_data  (m_axis_tdata),
    .m_user  (m_axis_tuser),
    .m_last  (m_axis_tlast)
  );

endmodule

@@ design/mfd_checker.sv @@
`timescale 1ns / 1ps
`include "message_frame_deframer_assert.svh"

// Port-level checks on the result stream.
module mfd_checker import mfd_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic [TUSER_W-1:0] m_axis_tuser,
  input logic               m_axis_tlast
);

  logic             stalled;
  logic             verr;
  logic             hdr_done;
  logic [2:0]       kind;
  logic             sig;
  logic [OFS_END-OFS_CMD-1:0] hdr_fields;

  assign stalled    = m_axis_tvalid && !m_axis_tready;
  assign verr       = m_axis_tvalid && m_axis_tuser[UOFS_VERR];
  assign hdr_done   = m_axis_tvalid && m_axis_tuser[UOFS_HDR];
  assign kind       = m_axis_tuser[UOFS_HDR-1:0];
  assign sig        = m_axis_tdata[OFS_SIGNED];
  assign hdr_fields = m_axis_tdata[OFS_END-1:OFS_CMD];

  // A stalled request keeps its payload
  `MFD_ASSERT_NEXT(a_hold, clk, rst, stalled, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // Version mismatch: header byte, no frame end, all frame fields cleared
  `MFD_ASSERT_IMPLY(a_verr, clk, rst, verr, kind == PH_HEADER && !m_axis_tlast && !sig && hdr_fields == '0 && !m_axis_tuser[UOFS_HDR])

  // Header completion only on a header byte
  `MFD_ASSERT_IMPLY(a_hdr, clk, rst, hdr_done, kind == PH_HEADER)

  // Signature and key bytes exist only in signed frames
  `MFD_ASSERT_IMPLY(a_key, clk, rst, m_axis_tvalid && (kind == PH_KEY || kind == PH_SIG), sig)

endmodule

bind message_frame_deframer mfd_checker u_mfd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

@@ tb/tb_message_frame_deframer.sv @@
`timescale 1ns / 1ps

module tb_message_frame_deframer;
  import mfd_pkg::*;

  localparam int SIG_LEN = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [7:0] byte_value, [8] signed_frame, [16:9] command_code,
  // [80:17] sequence_number, [96:81] topic_length, [128:97] payload_length,
  // [160:129] key_identifier, [167:161] zero
  logic [TDATA_W-1:0]  m_axis_tdata;
  // [2:0] byte_kind, [3] header_done, [4] version_error
  logic [TUSER_W-1:0]  m_axis_tuser;
  logic                m_axis_tlast;   // frame_done
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = REG_VERSION;
  logic [7:0]          cfg_data = 8'h00;

  message_frame_deframer #(.SIG_BYTES(SIG_LEN)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Bytes waiting to be sent, and decoded results waiting to be seen
  logic [7:0]  stream_bytes[$];
  mfd_result_t pending_results[$];

  // Handshakes seen at the last rising edge
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;

  // Idle control
  int src_wait = 0;
  int snk_wait = 0;
  bit src_burst = 1'b0;
  bit snk_burst = 1'b0;
  bit quiet = 1'b0;

  // Config as the stimulus knows it
  logic [7:0] ver_now = 8'd1;
  logic [7:0] pub_now = 8'd0;
  logic [7:0] msg_now = 8'd0;
  int n_pushed = 0;

  // Config as the block has taken it
  logic [7:0] seen_version = 8'd1;
  logic [7:0] seen_pub_code = 8'd0;
  logic [7:0] seen_msg_code = 8'd0;

  // Parser state of the predictor
  logic [2:0]  sect = PH_HEADER;
  logic [31:0] sect_pos = '0;
  logic [7:0]  f_command = '0;
  logic [63:0] f_sequence = '0;
  logic [15:0] f_topic_len = '0;
  logic [31:0] f_payload_len = '0;
  logic [31:0] f_key_id = '0;
  logic        f_signed = 1'b0;

  // Tallies
  int n_errors = 0;
  int n_results = 0;
  int n_frames = 0;
  int n_signed = 0;
  int n_verr = 0;
  int n_cfg_writes = 0;

  // First non-empty section after 'from'; header means the frame is over
  function automatic logic [2:0] section_following(input logic [2:0] from);
    if (from < PH_TOPIC && f_topic_len != 0) return PH_TOPIC;
    if (from < PH_PAYLOAD && f_payload_len != 0) return PH_PAYLOAD;
    if (from < PH_SIG && f_signed) return PH_SIG;
    if (from == PH_SIG) return PH_KEY;
    return PH_HEADER;
  endfunction

  // Decode one stream byte and advance the parser
  function automatic mfd_result_t deframe_byte(input logic [7:0] b);
    mfd_result_t r;
    logic [31:0] sect_len;
    logic        hdr_done;
    logic        verr;
    logic        frm_done;
    logic [2:0]  nxt;
    r = '0;
    sect_len = '0;
    hdr_done = 1'b0;
    verr = 1'b0;
    frm_done = 1'b0;
    if (sect > PH_KEY) sect = PH_HEADER;
    r.byte_kind = sect;
    case (sect)
      PH_TOPIC:   sect_len = 32'(f_topic_len);
      PH_PAYLOAD: sect_len = f_payload_len;
      PH_SIG:     sect_len = 32'(SIG_LEN);
      PH_KEY: begin
        sect_len = KEY_BYTES;
        f_key_id = {f_key_id[23:0], b};
      end
      default: begin
        if (sect_pos == 0) begin
          // frame start clears every header field
          f_command = '0;
          f_sequence = '0;
          f_topic_len = '0;
          f_payload_len = '0;
          f_key_id = '0;
          f_signed = 1'b0;
          if (b != seen_version) verr = 1'b1;
        end else if (sect_pos == 1) begin
          f_command = b;
          f_signed = (b == seen_pub_code) || (b == seen_msg_code);
        end else if (sect_pos < 10) begin
          f_sequence = {f_sequence[55:0], b};
        end else if (sect_pos < 12) begin
          f_topic_len = {f_topic_len[7:0], b};
        end else begin
          f_payload_len = {f_payload_len[23:0], b};
        end
        sect_len = HDR_BYTES;
        if (sect_pos + 1 >= HDR_BYTES) hdr_done = 1'b1;
      end
    endcase

    if (verr) begin
      sect = PH_HEADER;
      sect_pos = '0;
    end else if (sect_len == 0 || {1'b0, sect_pos} + 33'd1 >= {1'b0, sect_len}) begin
      nxt = section_following(sect);
      frm_done = (nxt == PH_HEADER);
      sect = nxt;
      sect_pos = '0;
    end else begin
      sect_pos = sect_pos + 1;
    end

    r.byte_value = b;
    r.header_done = hdr_done;
    r.frame_done = frm_done;
    r.signed_frame = f_signed;
    r.command_code = f_command;
    r.sequence_number = f_sequence;
    r.topic_length = f_topic_len;
    r.payload_length = f_payload_len;
    r.key_identifier = f_key_id;
    r.version_error = verr;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endtask

  // Wait count for one request; bursts with no idling come and go
  function automatic int draw_wait(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return (burst || quiet) ? 0 : $urandom_range(0, 10);
  endfunction

  // Byte source
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (src_wait > 0) begin
        s_axis_tvalid <= 1'b0;
        src_wait--;
      end else if (stream_bytes.size() != 0) begin
        s_axis_tdata <= stream_bytes.pop_front();
        s_axis_tvalid <= 1'b1;
        src_wait = draw_wait(src_burst);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result sink with random back-pressure
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (out_fire) snk_wait = draw_wait(snk_burst);
      if (snk_wait > 0) begin
        m_axis_tready <= 1'b0;
        snk_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: check results, track config writes, predict accepted bytes
  always @(posedge clk) begin
    mfd_result_t got;
    mfd_result_t want;
    mfd_result_t pred;
    in_fire <= !rst && s_axis_tvalid && s_axis_tready;
    out_fire <= !rst && m_axis_tvalid && m_axis_tready;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.byte_kind = m_axis_tuser[2:0];
        got.byte_value = m_axis_tdata[7:0];
        got.header_done = m_axis_tuser[UOFS_HDR];
        got.frame_done = m_axis_tlast;
        got.signed_frame = m_axis_tdata[OFS_SIGNED];
        got.command_code = m_axis_tdata[OFS_CMD +: 8];
        got.sequence_number = m_axis_tdata[OFS_SEQ +: 64];
        got.topic_length = m_axis_tdata[OFS_TOPIC +: 16];
        got.payload_length = m_axis_tdata[OFS_PAYLOAD +: 32];
        got.key_identifier = m_axis_tdata[OFS_KEY +: 32];
        got.version_error = m_axis_tuser[UOFS_VERR];
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: byte 0x%0h", got.byte_value);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          n_results++;
          if (want.frame_done) n_frames++;
          if (want.frame_done && want.signed_frame) n_signed++;
          if (want.version_error) n_verr++;
          check_field("byte_kind", want.byte_kind, got.byte_kind);
          check_field("byte_value", want.byte_value, got.byte_value);
          check_field("header_done", want.header_done, got.header_done);
          check_field("frame_done", want.frame_done, got.frame_done);
          check_field("signed_frame", want.signed_frame, got.signed_frame);
          check_field("command_code", want.command_code, got.command_code);
          check_field("sequence_number", want.sequence_number, got.sequence_number);
          check_field("topic_length", want.topic_length, got.topic_length);
          check_field("payload_length", want.payload_length, got.payload_length);
          check_field("key_identifier", want.key_identifier, got.key_identifier);
          check_field("version_error", want.version_error, got.version_error);
          check_field("tdata_pad", '0, m_axis_tdata[TDATA_W-1:OFS_END]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        n_cfg_writes++;
        case (cfg_index)
          REG_VERSION:    seen_version = cfg_data;
          REG_SIGNED_PUB: seen_pub_code = cfg_data;
          REG_SIGNED_MSG: seen_msg_code = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pred = deframe_byte(s_axis_tdata);
        pending_results = {pending_results, pred};
      end
    end
  end

  // ---------------- stimulus helpers ----------------

  task automatic push_byte(input logic [7:0] b);
    stream_bytes = {stream_bytes, b};
    n_pushed++;
  endtask

  // Full frame with random topic, payload and tail bytes
  task automatic push_frame(input logic [7:0] cmd, input logic [63:0] seq,
                            input logic [15:0] tlen, input logic [31:0] plen);
    logic [127:0] hdr;
    hdr = {ver_now, cmd, seq, tlen, plen};
    for (int i = 15; i >= 0; i--) push_byte(hdr[i*8 +: 8]);
    repeat (tlen) push_byte(8'($urandom_range(0, 255)));
    repeat (plen) push_byte(8'($urandom_range(0, 255)));
    if (cmd == pub_now || cmd == msg_now)
      repeat (SIG_LEN + KEY_BYTES) push_byte(8'($urandom_range(0, 255)));
  endtask

  // Bytes that never match the version while waiting for a header start
  task automatic push_noise(input int count);
    logic [7:0] b;
    repeat (count) begin
      b = 8'($urandom_range(0, 255));
      if (b == ver_now) b = ~b;
      push_byte(b);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_VERSION:    ver_now = val;
      REG_SIGNED_PUB: pub_now = val;
      REG_SIGNED_MSG: msg_now = val;
      default: ;
    endcase
  endtask

  task automatic set_codes(input logic [7:0] ver, input logic [7:0] pub,
                           input logic [7:0] msg);
    write_reg(REG_VERSION, ver);
    write_reg(REG_SIGNED_PUB, pub);
    write_reg(REG_SIGNED_MSG, msg);
  endtask

  // Wait until every sent byte has come back, then wait out the given tail
  task automatic settle(input int tail);
    while (stream_bytes.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
      @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Mostly small sections, now and then a length past one byte
  function automatic logic [31:0] pick_len();
    int r;
    r = $urandom_range(0, 49);
    if (r < 12) return 0;
    if (r < 44) return $urandom_range(1, 8);
    if (r < 49) return $urandom_range(9, 40);
    return $urandom_range(256, 270);
  endfunction

  // Well-formed frames with random content, some noise between them
  task automatic run_random(input int count);
    int stop_at;
    int r;
    logic [7:0] cmd;
    stop_at = n_pushed + count;
    while (n_pushed < stop_at) begin
      if ($urandom_range(0, 99) < 8) begin
        push_noise($urandom_range(1, 3));
      end else begin
        r = $urandom_range(0, 9);
        if (r < 2) cmd = pub_now;
        else if (r == 2) cmd = msg_now;
        else cmd = 8'($urandom_range(0, 255));
        push_frame(cmd, {$urandom, $urandom}, 16'(pick_len()), pick_len());
      end
    end
    settle(4);
  endtask

  // ---------------- test sequence ----------------

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Reset config: version 1, both signed codes 0
    push_byte(8'h00);
    push_byte(8'hFF);
    push_frame(8'h07, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 32'd0);  // ends on header
    push_frame(8'hFF, 64'h0, 16'd3, 32'd0);
    push_frame(8'h80, 64'h0123_4567_89AB_CDEF, 16'd0, 32'd2);
    push_frame(8'h00, {$urandom, $urandom}, 16'd0, 32'd0);    // signed, no body
    push_frame(8'h00, {$urandom, $urandom}, 16'd2, 32'd1);
    push_byte(8'h02);
    settle(4);

    // New version and codes; old version byte must now be flagged
    set_codes(8'hFF, 8'hAB, 8'hCD);
    push_byte(8'h01);
    push_frame(8'hAB, {$urandom, $urandom}, 16'd1, 32'd1);
    push_frame(8'hCD, {$urandom, $urandom}, 16'd0, 32'd0);
    push_frame(8'h00, {$urandom, $urandom}, 16'd0, 32'd0);    // code 0 now unsigned
    push_frame(8'h11, {$urandom, $urandom}, 16'h0102, 32'h0000_0101);
    settle(4);

    // Random traffic under several settings
    set_codes(8'h00, 8'hFF, 8'h3C);
    run_random(130);
    set_codes(8'hFF, 8'h00, 8'hFF);
    run_random(130);
    set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
    run_random(130);
    set_codes(8'hA5, 8'h42, 8'h42);
    run_random(130);

    // One signed frame streamed with no idling on either side
    quiet = 1'b1;
    push_frame(pub_now, {$urandom, $urandom}, 16'd3, 32'h0000_0120);
    settle(10);

    $display("Checked %0d results: %0d frames (%0d signed), %0d version errors,",
             n_results, n_frames, n_signed, n_verr);
    $display("  %0d register writes across five settings", n_cfg_writes);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
